@@ hdl/afp_pkg.sv @@
package afp_pkg;

  // Fractional bits of the input coordinates.
  localparam int IN_FRAC = 4;

  // Quotient bits resolved by a divider lane, one per stage.
  localparam int QBITS = 33;

  // Depth of one divider lane: its quotient-bit stages plus saturation.
  localparam int LANE_LAT = QBITS + 1;

  // Number of coefficient lanes and their order.
  localparam int NLANES  = 4;
  localparam int LANE_SX = 0;
  localparam int LANE_KX = 1;
  localparam int LANE_KY = 2;
  localparam int LANE_SY = 3;

  localparam int OUT_W = 32;
  localparam logic [OUT_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] SAT_MIN = 32'h8000_0000;

endpackage

@@ hdl/afp_if.sv @@
interface afp_in_if #(
  parameter int CW = 16
);
  logic valid;
  logic ready;
  logic signed [CW-1:0] src_a_x;
  logic signed [CW-1:0] src_a_y;
  logic signed [CW-1:0] src_b_x;
  logic signed [CW-1:0] src_b_y;
  logic signed [CW-1:0] src_c_x;
  logic signed [CW-1:0] src_c_y;
  logic signed [CW-1:0] dst_a_x;
  logic signed [CW-1:0] dst_a_y;
  logic signed [CW-1:0] dst_b_x;
  logic signed [CW-1:0] dst_b_y;
  logic signed [CW-1:0] dst_c_x;
  logic signed [CW-1:0] dst_c_y;

  modport source (
    output valid, src_a_x, src_a_y, src_b_x, src_b_y, src_c_x, src_c_y,
    output dst_a_x, dst_a_y, dst_b_x, dst_b_y, dst_c_x, dst_c_y,
    input ready
  );
  modport sink (
    input valid, src_a_x, src_a_y, src_b_x, src_b_y, src_c_x, src_c_y,
    input dst_a_x, dst_a_y, dst_b_x, dst_b_y, dst_c_x, dst_c_y,
    output ready
  );
endinterface

interface afp_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] scale_x;
  logic signed [31:0] skew_x;
  logic signed [31:0] skew_y;
  logic signed [31:0] scale_y;
  logic signed [31:0] trans_x;
  logic signed [31:0] trans_y;
  logic degenerate;

  modport source (
    output valid, scale_x, skew_x, skew_y, scale_y, trans_x, trans_y, degenerate,
    input ready
  );
  modport sink (
    input valid, scale_x, skew_x, skew_y, scale_y, trans_x, trans_y, degenerate,
    output ready
  );
endinterface

@@ hdl/affine_from_three_point_pairs.sv @@
// Affine transform from three point pairs.
// An item on in_ch carries three source and three destination points, each
// coordinate a signed fixed-point value with four fractional bits. Point a of
// each set is the reference. One item comes out on out_ch for every item in:
// the 2x3 affine matrix that maps the sources onto the destinations, each
// entry a signed 32-bit value with OUT_FRAC_BITS fractional bits, saturated.
// Collinear sources set degenerate and zero all six matrix entries.
// Both channels use valid/ready; an item moves when both are high.
// From acceptance to out_ch.valid an item passes three front stages
// (offsets, products, determinant), 33 divider stages plus one saturation
// stage in each of four coefficient lanes, and three translation stages.
// Throughput is one item per cycle when not stalled; the four lanes each
// run their own pipelined divider; divider depth sets latency, not rate.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ch.ready drops in the same cycle; it rises again when the result
// is taken. Synchronous reset empties the pipeline and drops out_ch.valid.
module affine_from_three_point_pairs #(
  parameter int COORD_WIDTH   = 16,
  parameter int OUT_FRAC_BITS = 16
) (
  input logic clk,
  input logic rst_n,
  afp_in_if.sink    in_ch,
  afp_out_if.source out_ch
);
  import afp_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int DW = 2 * (CW + 1) + 1;
  localparam int NW = DW + OUT_FRAC_BITS + 2;

  logic en;
  logic front_vld;
  logic [NW-1:0] n_w [NLANES];
  logic [DW:0] d2_w;
  logic neg_w [NLANES];
  logic degen_w;
  logic signed [CW-1:0] sax_w, say_w, dax_w, day_w;
  logic [31:0] coef_w [NLANES];
  logic [31:0] coef_out [NLANES];

  // Side information delayed alongside the divider lanes.
  logic [LANE_LAT-1:0] vld_r;
  logic [LANE_LAT-1:0] degen_r;
  logic signed [CW-1:0] sax_r [LANE_LAT];
  logic signed [CW-1:0] say_r [LANE_LAT];
  logic signed [CW-1:0] dax_r [LANE_LAT];
  logic signed [CW-1:0] day_r [LANE_LAT];

  // The pipeline advances unless a finished result is waiting on a stall.
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  afp_front #(.CW(CW), .OFB(OUT_FRAC_BITS)) u_front (
    .clk, .rst_n, .en,
    .vld_i(in_ch.valid),
    .sax_i(in_ch.src_a_x), .say_i(in_ch.src_a_y),
    .sbx_i(in_ch.src_b_x), .sby_i(in_ch.src_b_y),
    .scx_i(in_ch.src_c_x), .scy_i(in_ch.src_c_y),
    .dax_i(in_ch.dst_a_x), .day_i(in_ch.dst_a_y),
    .dbx_i(in_ch.dst_b_x), .dby_i(in_ch.dst_b_y),
    .dcx_i(in_ch.dst_c_x), .dcy_i(in_ch.dst_c_y),
    .vld_o(front_vld),
    .n_o(n_w), .d2_o(d2_w), .neg_o(neg_w), .degen_o(degen_w),
    .sax_o(sax_w), .say_o(say_w), .dax_o(dax_w), .day_o(day_w)
  );

  // One divider lane per linear coefficient, all sharing the determinant.
  for (genvar i = 0; i < NLANES; i++) begin : g_lane
    afp_lane #(.CW(CW), .OFB(OUT_FRAC_BITS)) u_lane (
      .clk, .en,
      .n_i(n_w[i]), .d2_i(d2_w), .neg_i(neg_w[i]),
      .coef_o(coef_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LANE_LAT-2:0], front_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degen_r <= {degen_r[LANE_LAT-2:0], degen_w};
      sax_r[0] <= sax_w;
      say_r[0] <= say_w;
      dax_r[0] <= dax_w;
      day_r[0] <= day_w;
      for (int k = 1; k < LANE_LAT; k++) begin
        sax_r[k] <= sax_r[k-1];
        say_r[k] <= say_r[k-1];
        dax_r[k] <= dax_r[k-1];
        day_r[k] <= day_r[k-1];
      end
    end
  end

  // Translations from the saturated coefficients, then the output register.
  afp_merge #(.CW(CW), .OFB(OUT_FRAC_BITS)) u_merge (
    .clk, .rst_n, .en,
    .vld_i(vld_r[LANE_LAT-1]),
    .coef_i(coef_w),
    .sax_i(sax_r[LANE_LAT-1]), .say_i(say_r[LANE_LAT-1]),
    .dax_i(dax_r[LANE_LAT-1]), .day_i(day_r[LANE_LAT-1]),
    .degen_i(degen_r[LANE_LAT-1]),
    .vld_o(out_ch.valid),
    .coef_o(coef_out),
    .tx_o(out_ch.trans_x), .ty_o(out_ch.trans_y),
    .degen_o(out_ch.degenerate)
  );

  assign out_ch.scale_x = coef_out[LANE_SX];
  assign out_ch.skew_x  = coef_out[LANE_KX];
  assign out_ch.skew_y  = coef_out[LANE_KY];
  assign out_ch.scale_y = coef_out[LANE_SY];

`ifndef SYNTHESIS
  // A degenerate result carries an all-zero matrix.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.degenerate |->
      out_ch.scale_x == 0 && out_ch.skew_x == 0 && out_ch.skew_y == 0 &&
      out_ch.scale_y == 0 && out_ch.trans_x == 0 && out_ch.trans_y == 0)
    else $error("degenerate result with nonzero matrix");

  // A stall freezes the items in flight through the lanes.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("lane pipeline moved during a stall");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");
`endif

endmodule

@@ hdl/afp_front.sv @@
module afp_front #(
  parameter int CW  = 16,
  parameter int OFB = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic vld_i,
  input  logic signed [CW-1:0] sax_i, say_i, sbx_i, sby_i, scx_i, scy_i,
  input  logic signed [CW-1:0] dax_i, day_i, dbx_i, dby_i, dcx_i, dcy_i,
  output logic vld_o,
  output logic [2*CW+OFB+4:0] n_o [afp_pkg::NLANES],
  output logic [2*CW+3:0] d2_o,
  output logic neg_o [afp_pkg::NLANES],
  output logic degen_o,
  output logic signed [CW-1:0] sax_o, say_o, dax_o, day_o
);
  import afp_pkg::*;

  localparam int OW = CW + 1;
  localparam int PW = 2 * OW;
  localparam int DW = PW + 1;
  localparam int NW = DW + OFB + 2;

  logic [2:0] vld_r;

  // Stage A: offsets from the reference points.
  logic signed [OW-1:0] ux_r, uy_r, vx_r, vy_r, bux_r, buy_r, bvx_r, bvy_r;
  logic signed [CW-1:0] sax_a_r, say_a_r, dax_a_r, day_a_r;

  // Stage B: the ten cross products.
  logic signed [PW-1:0] p_r [10];
  logic signed [CW-1:0] sax_b_r, say_b_r, dax_b_r, day_b_r;

  // Stage C combinational differences.
  logic signed [DW-1:0] det;
  logic signed [DW-1:0] num [NLANES];
  logic [DW-1:0] det_mag;
  logic [DW-1:0] num_mag [NLANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r  <= OW'(sbx_i) - OW'(sax_i);
      uy_r  <= OW'(sby_i) - OW'(say_i);
      vx_r  <= OW'(scx_i) - OW'(sax_i);
      vy_r  <= OW'(scy_i) - OW'(say_i);
      bux_r <= OW'(dbx_i) - OW'(dax_i);
      buy_r <= OW'(dby_i) - OW'(day_i);
      bvx_r <= OW'(dcx_i) - OW'(dax_i);
      bvy_r <= OW'(dcy_i) - OW'(day_i);
      sax_a_r <= sax_i;
      say_a_r <= say_i;
      dax_a_r <= dax_i;
      day_a_r <= day_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= PW'(ux_r) * PW'(vy_r);
      p_r[1] <= PW'(uy_r) * PW'(vx_r);
      p_r[2] <= PW'(bux_r) * PW'(vy_r);
      p_r[3] <= PW'(bvx_r) * PW'(uy_r);
      p_r[4] <= PW'(ux_r) * PW'(bvx_r);
      p_r[5] <= PW'(vx_r) * PW'(bux_r);
      p_r[6] <= PW'(buy_r) * PW'(vy_r);
      p_r[7] <= PW'(bvy_r) * PW'(uy_r);
      p_r[8] <= PW'(ux_r) * PW'(bvy_r);
      p_r[9] <= PW'(vx_r) * PW'(buy_r);
      sax_b_r <= sax_a_r;
      say_b_r <= say_a_r;
      dax_b_r <= dax_a_r;
      day_b_r <= day_a_r;
    end
  end

  always_comb begin
    det = DW'(p_r[0]) - DW'(p_r[1]);
    det_mag = det[DW-1] ? DW'(-det) : DW'(det);
    for (int i = 0; i < NLANES; i++) begin
      num[i] = DW'(p_r[2 + 2 * i]) - DW'(p_r[3 + 2 * i]);
      num_mag[i] = num[i][DW-1] ? DW'(-num[i]) : DW'(num[i]);
    end
  end

  // Stage C: rounded-division operands, 2|n|*2^F + |d| over 2|d|.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NLANES; i++) begin
        n_o[i]   <= (NW'(num_mag[i]) << (OFB + 1)) + NW'(det_mag);
        neg_o[i] <= num[i][DW-1] ^ det[DW-1];
      end
      d2_o    <= {det_mag, 1'b0};
      degen_o <= (det == '0);
      sax_o   <= sax_b_r;
      say_o   <= say_b_r;
      dax_o   <= dax_b_r;
      day_o   <= day_b_r;
    end
  end

  assign vld_o = vld_r[2];

endmodule

@@ hdl/afp_lane.sv @@
module afp_lane #(
  parameter int CW  = 16,
  parameter int OFB = 16
) (
  input  logic clk,
  input  logic en,
  input  logic [2*CW+OFB+4:0] n_i,
  input  logic [2*CW+3:0] d2_i,
  input  logic neg_i,
  output logic [31:0] coef_o
);
  import afp_pkg::*;

  localparam int DW = 2 * (CW + 1) + 1;
  localparam int NW = DW + OFB + 2;
  localparam int XW = DW + QBITS + 1;

  logic [XW-1:0]    rem_r [QBITS];
  logic [XW-1:0]    dv_r  [QBITS];
  logic [QBITS-1:0] q_r   [QBITS];
  logic             neg_r [QBITS];
  logic             ovf_r [QBITS];

  // One restoring step per stage, most significant quotient bit first.
  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    logic [XW-1:0]    rem_in, dv_in, sh;
    logic [QBITS-1:0] q_in, q_set;
    logic             neg_in, ovf_in;

    if (k == 0) begin : g_first
      assign rem_in = {{(XW-NW){1'b0}}, n_i};
      assign dv_in  = {{(XW-DW-1){1'b0}}, d2_i};
      assign q_in   = '0;
      assign neg_in = neg_i;
      assign ovf_in = rem_in >= (dv_in << QBITS);
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign dv_in  = dv_r[k-1];
      assign q_in   = q_r[k-1];
      assign neg_in = neg_r[k-1];
      assign ovf_in = ovf_r[k-1];
    end

    assign sh = dv_in << (QBITS - 1 - k);
    assign q_set = q_in | ({{(QBITS-1){1'b0}}, (rem_in >= sh)} << (QBITS - 1 - k));

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= (rem_in >= sh) ? rem_in - sh : rem_in;
        q_r[k]   <= q_set;
        dv_r[k]  <= dv_in;
        neg_r[k] <= neg_in;
        ovf_r[k] <= ovf_in;
      end
    end
  end

  logic [QBITS-1:0] mag;
  logic [QBITS-1:0] mag_neg;
  assign mag     = q_r[QBITS-1];
  assign mag_neg = -mag;

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_r[QBITS-1]) begin
        if (ovf_r[QBITS-1] || mag > {1'b0, SAT_MIN}) begin
          coef_o <= SAT_MIN;
        end else begin
          coef_o <= mag_neg[31:0];
        end
      end else begin
        if (ovf_r[QBITS-1] || mag > {1'b0, SAT_MAX}) begin
          coef_o <= SAT_MAX;
        end else begin
          coef_o <= mag[31:0];
        end
      end
    end
  end

endmodule

@@ hdl/afp_merge.sv @@
module afp_merge #(
  parameter int CW  = 16,
  parameter int OFB = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic vld_i,
  input  logic [31:0] coef_i [afp_pkg::NLANES],
  input  logic signed [CW-1:0] sax_i, say_i, dax_i, day_i,
  input  logic degen_i,
  output logic vld_o,
  output logic [31:0] coef_o [afp_pkg::NLANES],
  output logic [31:0] tx_o,
  output logic [31:0] ty_o,
  output logic degen_o
);
  import afp_pkg::*;

  localparam int MW = CW + 32;
  localparam int SW = CW + 33;
  localparam int TW = CW + 34;
  localparam logic signed [TW-1:0] HI = {{(TW-32){1'b0}}, SAT_MAX};
  localparam logic signed [TW-1:0] LO = {{(TW-32){1'b1}}, SAT_MIN};

  logic [2:0] vld_r;

  logic signed [MW-1:0] p_r [4];
  logic [31:0] c1_r [NLANES];
  logic [31:0] c2_r [NLANES];
  logic signed [CW-1:0] dax1_r, day1_r, dax2_r, day2_r;
  logic degen1_r, degen2_r;
  logic signed [TW-1:0] scx_r, scy_r;

  logic signed [SW-1:0] sum_x, sum_y;
  logic [SW-1:0] mag_x, mag_y, rnd_x, rnd_y;
  logic signed [TW-1:0] res_x, res_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= MW'(sax_i) * MW'($signed(coef_i[LANE_SX]));
      p_r[1] <= MW'(say_i) * MW'($signed(coef_i[LANE_KX]));
      p_r[2] <= MW'(sax_i) * MW'($signed(coef_i[LANE_KY]));
      p_r[3] <= MW'(say_i) * MW'($signed(coef_i[LANE_SY]));
      c1_r     <= coef_i;
      dax1_r   <= dax_i;
      day1_r   <= day_i;
      degen1_r <= degen_i;
    end
  end

  // Divide the sums by 16, rounding half away from zero.
  always_comb begin
    sum_x = SW'(p_r[0]) + SW'(p_r[1]);
    sum_y = SW'(p_r[2]) + SW'(p_r[3]);
    mag_x = sum_x[SW-1] ? SW'(-sum_x) : SW'(sum_x);
    mag_y = sum_y[SW-1] ? SW'(-sum_y) : SW'(sum_y);
    rnd_x = (mag_x + SW'(1 << (IN_FRAC - 1))) >> IN_FRAC;
    rnd_y = (mag_y + SW'(1 << (IN_FRAC - 1))) >> IN_FRAC;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      scx_r    <= sum_x[SW-1] ? -$signed(TW'(rnd_x)) : $signed(TW'(rnd_x));
      scy_r    <= sum_y[SW-1] ? -$signed(TW'(rnd_y)) : $signed(TW'(rnd_y));
      c2_r     <= c1_r;
      dax2_r   <= dax1_r;
      day2_r   <= day1_r;
      degen2_r <= degen1_r;
    end
  end

  assign res_x = (TW'(dax2_r) <<< (OFB - IN_FRAC)) - scx_r;
  assign res_y = (TW'(day2_r) <<< (OFB - IN_FRAC)) - scy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      degen_o <= degen2_r;
      for (int i = 0; i < NLANES; i++) begin
        coef_o[i] <= degen2_r ? '0 : c2_r[i];
      end
      if (degen2_r) begin
        tx_o <= '0;
      end else if (res_x > HI) begin
        tx_o <= SAT_MAX;
      end else if (res_x < LO) begin
        tx_o <= SAT_MIN;
      end else begin
        tx_o <= res_x[31:0];
      end
      if (degen2_r) begin
        ty_o <= '0;
      end else if (res_y > HI) begin
        ty_o <= SAT_MAX;
      end else if (res_y < LO) begin
        ty_o <= SAT_MIN;
      end else begin
        ty_o <= res_y[31:0];
      end
    end
  end

  assign vld_o = vld_r[2];

endmodule
